### rtl/core/drqfc_pkg.sv
// Shared types and codes for the DRQ flow-control slot placer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package drqfc_pkg;

    typedef enum logic [2:0] {
        SLOT_IDLE   = 3'd0,
        SLOT_DRQ    = 3'd1,
        SLOT_GUARD0 = 3'd2,
        SLOT_GUARD1 = 3'd3,
        SLOT_TAIL   = 3'd4
    } slot_kind_t;

    typedef enum logic [2:0] {
        REG_PORT_MODE       = 3'd0,
        REG_NUM_COLUMNS     = 3'd1,
        REG_INTERVAL_ROWS   = 3'd2,
        REG_DRQ_ROW         = 3'd3,
        REG_DRQ_COLUMN      = 3'd4,
        REG_DRQ_EXTRA_WIDTH = 3'd5,
        REG_GUARD_MODE      = 3'd6,
        REG_TAIL_TICKS      = 3'd7
    } reg_index_t;

    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned MAX_COLUMNS = 16;

    typedef struct packed {
        logic [1:0]  port_mode;
        logic [4:0]  num_columns;
        logic [11:0] interval_rows;
        logic [11:0] drq_row;
        logic [3:0]  drq_column;
        logic [3:0]  drq_extra_width;
        logic [1:0]  guard_mode;
        logic [3:0]  tail_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  column_count;
        logic [12:0] row_count;
        logic        drq_done;
        logic [3:0]  replay_left;
        logic        guard_due;
        logic [3:0]  tail_left;
    } placer_state_t;

    typedef struct packed {
        slot_kind_t slot_kind;
        logic       sample_point;
        logic       drq_source;
    } slot_result_t;

endpackage

### rtl/core/drqfc_if.sv
// Valid/ready channel interfaces for tick items in and slot items out.
// Depends on nothing but each other's style; compiled after drqfc_pkg.
`timescale 1ns / 1ps

interface drqfc_tick_if;
    logic valid;
    logic ready;
    logic interval_skipped;

    modport source (output valid, output interval_skipped, input ready);
    modport sink   (input valid, input interval_skipped, output ready);
endinterface

interface drqfc_slot_if;
    logic       valid;
    logic       ready;
    logic [2:0] slot_kind;
    logic       sample_point;
    logic       drq_source;

    modport source (output valid, output slot_kind, output sample_point,
                    output drq_source, input ready);
    modport sink   (input valid, input slot_kind, input sample_point,
                    input drq_source, output ready);
endinterface

### rtl/core/drqfc_slot_logic.sv
// Per-tick slot decision and counter advance, purely combinational.
// Depends on drqfc_pkg.
`timescale 1ns / 1ps

module drqfc_slot_logic (
    input  drqfc_pkg::cfg_t          cfg,
    input  drqfc_pkg::placer_state_t state_cur,
    input  logic                     interval_skipped,
    output drqfc_pkg::placer_state_t state_next,
    output drqfc_pkg::slot_result_t  result
);
    import drqfc_pkg::*;

    logic          source;
    logic          enabled;
    logic [4:0]    cols;
    logic [4:0]    col_inc;
    logic [12:0]   row_inc;
    placer_state_t st;

    always_comb
    begin
        source  = cfg.port_mode[0];
        enabled = cfg.port_mode[1];
        st      = state_cur;

        result.slot_kind    = SLOT_IDLE;
        result.sample_point = 1'b0;
        result.drq_source   = source;

        if (state_cur.drq_done && state_cur.replay_left != 4'd0)
        begin
            result.slot_kind    = SLOT_DRQ;
            result.sample_point = !source && state_cur.replay_left == 4'd1;
            st.replay_left      = state_cur.replay_left - 4'd1;
        end
        else if (enabled && !interval_skipped && !state_cur.drq_done &&
                 state_cur.row_count == {1'b0, cfg.drq_row} &&
                 state_cur.column_count == cfg.drq_column)
        begin
            result.slot_kind    = SLOT_DRQ;
            result.sample_point = source || cfg.drq_extra_width == 4'd0;
            st.drq_done         = 1'b1;
            st.guard_due        = source && cfg.guard_mode != 2'd0;
            st.tail_left        = source ? cfg.tail_ticks : 4'd0;
            st.replay_left      = cfg.drq_extra_width;
        end
        else if (state_cur.guard_due)
        begin
            result.slot_kind = cfg.guard_mode[1] ? SLOT_GUARD1 : SLOT_GUARD0;
            st.guard_due     = 1'b0;
        end
        else if (state_cur.tail_left != 4'd0)
        begin
            result.slot_kind = SLOT_TAIL;
            st.tail_left     = state_cur.tail_left - 4'd1;
        end

        // column count clamped to 1..16
        if (cfg.num_columns == 5'd0)
            cols = 5'd1;
        else if (cfg.num_columns > 5'(MAX_COLUMNS))
            cols = 5'(MAX_COLUMNS);
        else
            cols = cfg.num_columns;

        col_inc = {1'b0, st.column_count} + 5'd1;
        row_inc = st.row_count + 13'd1;

        state_next = st;
        if (col_inc >= cols)
        begin
            // row edge cuts off pending replay, guard and tail
            state_next.column_count = 4'd0;
            state_next.guard_due    = 1'b0;
            state_next.tail_left    = 4'd0;
            state_next.replay_left  = 4'd0;
            state_next.row_count    = row_inc;
            if (row_inc > {1'b0, cfg.interval_rows})
            begin
                state_next.row_count = 13'd0;
                state_next.drq_done  = 1'b0;
            end
        end
        else
        begin
            state_next.column_count = col_inc[3:0];
        end
    end

endmodule

### rtl/core/drq_flow_control_slot_placer.sv
// Top level of the DRQ flow-control slot placer: config registers, counter
// state, two-entry result buffer. Depends on drqfc_pkg, drqfc_if, drqfc_slot_logic.
`timescale 1ns / 1ps

// One tick item in gives one slot item out. A tick is accepted every cycle
// while the result buffer has room; its slot is decided in the same cycle
// from the counter state and registered into the result buffer. The
// two-entry result buffer keeps taking ticks into its skid entry while
// the consumer stalls; once both entries are full, ticks are held off until a
// slot is taken. Configuration is written through cfg_we/cfg_index/cfg_data
// and should only change while no ticks are in flight.

module drq_flow_control_slot_placer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  drqfc_pkg::reg_index_t             cfg_index,
    input  logic [drqfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    drqfc_tick_if.sink                        ticks,
    drqfc_slot_if.source                      slots
);
    import drqfc_pkg::*;

    cfg_t          cfg_reg;
    placer_state_t state_reg;
    placer_state_t state_next;
    slot_result_t  result;

    logic          out_valid_reg;
    logic          out_valid_next;
    slot_result_t  out_data_reg;
    slot_result_t  out_data_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    slot_result_t  skid_data_reg;
    slot_result_t  skid_data_next;

    logic          accept;
    logic          take;

    assign ticks.ready = !skid_valid_reg;
    assign accept      = ticks.valid && !skid_valid_reg;
    assign take        = out_valid_reg && slots.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.port_mode       <= 2'd0;
            cfg_reg.num_columns     <= 5'd2;
            cfg_reg.interval_rows   <= 12'd0;
            cfg_reg.drq_row         <= 12'd0;
            cfg_reg.drq_column      <= 4'd0;
            cfg_reg.drq_extra_width <= 4'd0;
            cfg_reg.guard_mode      <= 2'd0;
            cfg_reg.tail_ticks      <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PORT_MODE:       cfg_reg.port_mode       <= cfg_data[1:0];
                REG_NUM_COLUMNS:     cfg_reg.num_columns     <= cfg_data[4:0];
                REG_INTERVAL_ROWS:   cfg_reg.interval_rows   <= cfg_data[11:0];
                REG_DRQ_ROW:         cfg_reg.drq_row         <= cfg_data[11:0];
                REG_DRQ_COLUMN:      cfg_reg.drq_column      <= cfg_data[3:0];
                REG_DRQ_EXTRA_WIDTH: cfg_reg.drq_extra_width <= cfg_data[3:0];
                REG_GUARD_MODE:      cfg_reg.guard_mode      <= cfg_data[1:0];
                REG_TAIL_TICKS:      cfg_reg.tail_ticks      <= cfg_data[3:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    drqfc_slot_logic u_slot_logic (
        .cfg              (cfg_reg),
        .state_cur        (state_reg),
        .interval_skipped (ticks.interval_skipped),
        .state_next       (state_next),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = accept;
            out_data_next  = result;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign slots.valid        = out_valid_reg;
    assign slots.slot_kind    = out_data_reg.slot_kind;
    assign slots.sample_point = out_data_reg.sample_point;
    assign slots.drq_source   = out_data_reg.drq_source;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a head entry");

    a_sample_on_drq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.sample_point) |->
        out_data_reg.slot_kind == SLOT_DRQ)
        else $error("sample point on a non-DRQ slot");

    a_pending_needs_drq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.guard_due || state_reg.tail_left != 4'd0 ||
         state_reg.replay_left != 4'd0) |-> state_reg.drq_done)
        else $error("pending replay, guard or tail without a placed DRQ");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !slots.ready && accept) |=> skid_valid_reg)
        else $error("item accepted under stall was not buffered");

endmodule

### verif/drq_flow_control_slot_placer_test.sv
// Self-checking testbench for drq_flow_control_slot_placer: directed table, then random phases.
// Uses drqfc_pkg and the drqfc_tick_if / drqfc_slot_if channels from the RTL.
// A local slot predictor, or a literal slot in the directed table, checks every slot item.
`timescale 1ns / 1ps

module drq_flow_control_slot_placer_test;
    import drqfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned LONG_HOLD = 200;
    localparam int unsigned MAX_GAP = 18;

    typedef struct {
        bit           is_cfg;
        reg_index_t   idx;
        logic [11:0]  data;
        logic         skipped;
        bit           has_lit;
        slot_result_t lit;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    reg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drqfc_tick_if tick_ch ();
    drqfc_slot_if slot_ch ();

    drq_flow_control_slot_placer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ticks     (tick_ch),
        .slots     (slot_ch)
    );

    cfg_t           plc_cfg;
    placer_state_t  plc_state;
    slot_result_t   slot_due_q[$];
    stim_row_t      dir_rows[$];

    bit          idle_on = 1'b1;
    int unsigned holds_asked = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned settings_run = 0;
    int unsigned drq_seen = 0;
    int unsigned guard_seen = 0;
    int unsigned tail_seen = 0;
    int unsigned stalls_seen = 0;
    slot_result_t seen_slot;
    slot_result_t want_slot;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d slot items outstanding", $time, slot_due_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void placer_reset();
        plc_cfg = '0;
        plc_cfg.num_columns = 5'd2;
        plc_state = '0;
    endfunction

    function automatic slot_result_t predict_slot(logic skipped);
        logic         is_src;
        logic         is_en;
        logic [4:0]   col_lim;
        logic [4:0]   col_next;
        slot_result_t res;
        is_src = plc_cfg.port_mode[0];
        is_en = plc_cfg.port_mode[1];
        res.slot_kind = SLOT_IDLE;
        res.sample_point = 1'b0;
        res.drq_source = is_src;
        if (plc_state.drq_done && plc_state.replay_left != 4'd0)
        begin
            res.slot_kind = SLOT_DRQ;
            res.sample_point = !is_src && plc_state.replay_left == 4'd1;
            plc_state.replay_left = plc_state.replay_left - 4'd1;
        end
        else if (is_en && !skipped && !plc_state.drq_done
                 && plc_state.row_count == {1'b0, plc_cfg.drq_row}
                 && plc_state.column_count == plc_cfg.drq_column)
        begin
            res.slot_kind = SLOT_DRQ;
            res.sample_point = is_src || plc_cfg.drq_extra_width == 4'd0;
            plc_state.drq_done = 1'b1;
            plc_state.guard_due = is_src && plc_cfg.guard_mode != 2'd0;
            plc_state.tail_left = is_src ? plc_cfg.tail_ticks : 4'd0;
            plc_state.replay_left = plc_cfg.drq_extra_width;
        end
        else if (plc_state.guard_due)
        begin
            res.slot_kind = plc_cfg.guard_mode[1] ? SLOT_GUARD1 : SLOT_GUARD0;
            plc_state.guard_due = 1'b0;
        end
        else if (plc_state.tail_left != 4'd0)
        begin
            res.slot_kind = SLOT_TAIL;
            plc_state.tail_left = plc_state.tail_left - 4'd1;
        end

        col_lim = plc_cfg.num_columns;
        if (col_lim == 5'd0)
            col_lim = 5'd1;
        else if (col_lim > MAX_COLUMNS)
            col_lim = 5'(MAX_COLUMNS);
        col_next = {1'b0, plc_state.column_count} + 5'd1;
        if (col_next >= col_lim)
        begin
            plc_state.column_count = 4'd0;
            plc_state.guard_due = 1'b0;
            plc_state.tail_left = 4'd0;
            plc_state.replay_left = 4'd0;
            plc_state.row_count = plc_state.row_count + 13'd1;
            if (plc_state.row_count > {1'b0, plc_cfg.interval_rows})
            begin
                plc_state.row_count = 13'd0;
                plc_state.drq_done = 1'b0;
            end
        end
        else
        begin
            plc_state.column_count = col_next[3:0];
        end
        return res;
    endfunction

    function automatic slot_result_t slot_of(slot_kind_t k, logic smp, logic src);
        slot_result_t r;
        r.slot_kind = k;
        r.sample_point = smp;
        r.drq_source = src;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(reg_index_t idx, logic [11:0] val);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = val;
        r.skipped = 1'b0;
        r.has_lit = 1'b0;
        r.lit = '0;
        return r;
    endfunction

    function automatic stim_row_t tick_row(logic skip);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx = REG_PORT_MODE;
        r.data = '0;
        r.skipped = skip;
        r.has_lit = 1'b0;
        r.lit = '0;
        return r;
    endfunction

    function automatic stim_row_t tick_lit(logic skip, slot_kind_t k, logic smp, logic src);
        stim_row_t r;
        r = tick_row(skip);
        r.has_lit = 1'b1;
        r.lit = slot_of(k, smp, src);
        return r;
    endfunction

    // Register writes wait until every slot item is back, so the block is idle.
    task automatic write_reg(reg_index_t idx, logic [11:0] val, int unsigned fw);
        logic [11:0] word;
        word = val;
        if (fw < 12 && $urandom_range(0, 3) == 0)
            word = word | (12'($urandom()) << fw);
        tick_ch.valid <= 1'b0;
        while (slot_due_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PORT_MODE:       plc_cfg.port_mode = word[1:0];
            REG_NUM_COLUMNS:     plc_cfg.num_columns = word[4:0];
            REG_INTERVAL_ROWS:   plc_cfg.interval_rows = word[11:0];
            REG_DRQ_ROW:         plc_cfg.drq_row = word[11:0];
            REG_DRQ_COLUMN:      plc_cfg.drq_column = word[3:0];
            REG_DRQ_EXTRA_WIDTH: plc_cfg.drq_extra_width = word[3:0];
            REG_GUARD_MODE:      plc_cfg.guard_mode = word[1:0];
            REG_TAIL_TICKS:      plc_cfg.tail_ticks = word[3:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(logic skipped, bit has_lit, slot_result_t lit);
        int unsigned gap;
        slot_result_t pred;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.interval_skipped <= skipped;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        pred = predict_slot(skipped);
        slot_due_q.push_back(has_lit ? lit : pred);
        ticks_sent++;
    endtask

    // Slot side: random gaps per item, plus the long hold when asked.
    initial
    begin
        int unsigned wait_cycles;
        int unsigned holds_done;
        holds_done = 0;
        slot_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            wait_cycles = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (holds_done < holds_asked)
            begin
                wait_cycles = wait_cycles + LONG_HOLD;
                holds_done++;
            end
            if (wait_cycles != 0)
            begin
                slot_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            slot_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!slot_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tick_ch.valid && !tick_ch.ready)
            stalls_seen++;
        if (rst_n && slot_ch.valid && slot_ch.ready)
        begin
            seen_slot.slot_kind = slot_kind_t'(slot_ch.slot_kind);
            seen_slot.sample_point = slot_ch.sample_point;
            seen_slot.drq_source = slot_ch.drq_source;
            case (seen_slot.slot_kind)
                SLOT_DRQ:                 drq_seen++;
                SLOT_GUARD0, SLOT_GUARD1: guard_seen++;
                SLOT_TAIL:                tail_seen++;
                default: ;
            endcase
            if (slot_due_q.size() == 0)
            begin
                $display("%0t: slot item with none expected: kind %0d sample %0d src %0d",
                         $time, seen_slot.slot_kind, seen_slot.sample_point,
                         seen_slot.drq_source);
                fail_count++;
            end
            else
            begin
                want_slot = slot_due_q.pop_front();
                if (seen_slot.slot_kind !== want_slot.slot_kind)
                begin
                    $display("%0t: slot_kind expected %0d got %0d",
                             $time, want_slot.slot_kind, seen_slot.slot_kind);
                    fail_count++;
                end
                if (seen_slot.sample_point !== want_slot.sample_point)
                begin
                    $display("%0t: sample_point expected %0d got %0d",
                             $time, want_slot.sample_point, seen_slot.sample_point);
                    fail_count++;
                end
                if (seen_slot.drq_source !== want_slot.drq_source)
                begin
                    $display("%0t: drq_source expected %0d got %0d",
                             $time, want_slot.drq_source, seen_slot.drq_source);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned phase_no;
        int unsigned n_items;
        int unsigned cols;
        int unsigned irows;
        logic [1:0]  pmode;
        logic [11:0] v_row;
        logic [3:0]  v_col;
        logic [3:0]  v_extra;
        logic [1:0]  v_guard;
        logic [3:0]  v_tail;

        cfg_we <= 1'b0;
        cfg_index <= REG_PORT_MODE;
        cfg_data <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.interval_skipped <= 1'b0;
        placer_reset();

        // reset defaults: DRQ disabled
        dir_rows.push_back(tick_lit(1'b0, SLOT_IDLE, 1'b0, 1'b0));
        dir_rows.push_back(tick_lit(1'b1, SLOT_IDLE, 1'b0, 1'b0));
        // zero columns: every tick is a row edge and a new interval
        dir_rows.push_back(cfg_row(REG_PORT_MODE, 12'd3));
        dir_rows.push_back(cfg_row(REG_NUM_COLUMNS, 12'd0));
        dir_rows.push_back(tick_lit(1'b0, SLOT_DRQ, 1'b1, 1'b1));
        dir_rows.push_back(tick_lit(1'b1, SLOT_IDLE, 1'b0, 1'b1));
        // oversize column count, wide DRQ, guard mode three, tail
        dir_rows.push_back(cfg_row(REG_NUM_COLUMNS, 12'd31));
        dir_rows.push_back(cfg_row(REG_DRQ_EXTRA_WIDTH, 12'd2));
        dir_rows.push_back(cfg_row(REG_GUARD_MODE, 12'd3));
        dir_rows.push_back(cfg_row(REG_TAIL_TICKS, 12'd2));
        repeat (7) dir_rows.push_back(tick_row(1'b0));
        // sink DRQ, sampled on the last replay tick
        dir_rows.push_back(cfg_row(REG_PORT_MODE, 12'd2));
        dir_rows.push_back(cfg_row(REG_NUM_COLUMNS, 12'd3));
        repeat (4) dir_rows.push_back(tick_row(1'b0));
        // source side but disabled
        dir_rows.push_back(cfg_row(REG_PORT_MODE, 12'd1));
        dir_rows.push_back(tick_lit(1'b0, SLOT_IDLE, 1'b0, 1'b1));
        // narrow source DRQ with guard polarity zero
        dir_rows.push_back(cfg_row(REG_PORT_MODE, 12'd3));
        dir_rows.push_back(cfg_row(REG_GUARD_MODE, 12'd1));
        dir_rows.push_back(cfg_row(REG_DRQ_EXTRA_WIDTH, 12'd0));
        dir_rows.push_back(cfg_row(REG_TAIL_TICKS, 12'd0));
        repeat (5) dir_rows.push_back(tick_row(1'b0));
        // DRQ column past the column count
        dir_rows.push_back(cfg_row(REG_DRQ_COLUMN, 12'd5));
        repeat (3) dir_rows.push_back(tick_lit(1'b0, SLOT_IDLE, 1'b0, 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].idx, dir_rows[i].data, 12);
            else
                send_tick(dir_rows[i].skipped, dir_rows[i].has_lit, dir_rows[i].lit);
        end

        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            n_items = $urandom_range(10, 40);
            if (phase_no == 0)
            begin
                pmode = 2'd3; cols = 16; irows = 4095; v_row = 12'd4095;
                v_col = 4'd15; v_extra = 4'd15; v_guard = 2'd2; v_tail = 4'd15;
            end
            else if (phase_no == 1)
            begin
                pmode = 2'd3; cols = 16; irows = 0; v_row = 12'd0;
                v_col = 4'd15; v_extra = 4'd15; v_guard = 2'd3; v_tail = 4'd15;
                n_items = 40;
            end
            else if (phase_no == 2)
            begin
                pmode = 2'd0; cols = 0; irows = 0; v_row = 12'd0;
                v_col = 4'd0; v_extra = 4'd0; v_guard = 2'd0; v_tail = 4'd0;
            end
            else
            begin
                pmode = {1'($urandom_range(0, 4) != 0), 1'($urandom_range(0, 1))};
                cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 6);
                irows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, 3);
                v_row = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                     : 12'($urandom_range(0, irows + 1));
                v_col = 4'($urandom_range(0, (cols > 15) ? 15 : cols));
                v_extra = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                       : 4'($urandom_range(0, 15));
                v_guard = 2'($urandom_range(0, 3));
                v_tail = 4'($urandom_range(0, 15));
            end

            idle_on = 1'b1;
            write_reg(REG_PORT_MODE, 12'(pmode), 2);
            write_reg(REG_NUM_COLUMNS, 12'(cols), 5);
            write_reg(REG_INTERVAL_ROWS, 12'(irows), 12);
            write_reg(REG_DRQ_ROW, v_row, 12);
            write_reg(REG_DRQ_COLUMN, 12'(v_col), 4);
            write_reg(REG_DRQ_EXTRA_WIDTH, 12'(v_extra), 4);
            write_reg(REG_GUARD_MODE, 12'(v_guard), 2);
            write_reg(REG_TAIL_TICKS, 12'(v_tail), 4);
            settings_run++;

            idle_on = ($urandom_range(0, 3) != 0);
            if (phase_no == 4 || phase_no == 15)
            begin
                idle_on = 1'b0;
                holds_asked++;
            end

            repeat (n_items)
            begin
                send_tick(1'($urandom_range(0, 6) == 0), 1'b0, '0);
                random_sent++;
            end
            phase_no++;
        end

        tick_ch.valid <= 1'b0;
        while (slot_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d tick items over %0d random register settings, %0d input stalls.",
                 ticks_sent, settings_run, stalls_seen);
        $display("Slots seen: %0d DRQ, %0d guard, %0d tail; %0d mismatches.",
                 drq_seen, guard_seen, tail_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
